// ===== sv/dual_pump_off_delay_controller_core_assert.svh =====
// Assertion macros used by the pump controller merge module.
`ifndef DUAL_PUMP_OFF_DELAY_CONTROLLER_CORE_ASSERT_SVH
`define DUAL_PUMP_OFF_DELAY_CONTROLLER_CORE_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define DPODC_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Check that a trigger is followed by a consequence in the next clock cycle.
`define DPODC_ASSERT_NEXT(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/dpodc_pkg.sv =====
// Shared types and constants of the dual pump off-delay controller.
package dpodc_pkg;

	localparam int NUM_PUMPS = 2;
	localparam int ADDR_W    = 5;
	localparam int REG_IDX_W = 3;
	localparam int SAMPLE_W  = 10;
	localparam int DELAY_W   = 16;
	localparam int PERIOD_W  = 17;
	localparam int RUN_W     = 8;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_DELAY_DEFAULT  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_DELAY_LONG1    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_DELAY_LONG2    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_DELAY_LONG3    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_PROTECT_PERIOD = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_PROTECT_RUN    = 3'd5;

	// register reset values
	localparam logic [DELAY_W-1:0]  RST_DELAY_DEFAULT  = 16'd120;
	localparam logic [DELAY_W-1:0]  RST_DELAY_LONG1    = 16'd600;
	localparam logic [DELAY_W-1:0]  RST_DELAY_LONG2    = 16'd1200;
	localparam logic [DELAY_W-1:0]  RST_DELAY_LONG3    = 16'd1800;
	localparam logic [PERIOD_W-1:0] RST_PROTECT_PERIOD = 17'd86400;
	localparam logic [RUN_W-1:0]    RST_PROTECT_RUN    = 8'd60;

	// switch ladder decode levels
	localparam logic [SAMPLE_W-1:0] LADDER_PROTECT = 10'd512;
	localparam logic [SAMPLE_W-1:0] LADDER_LONG1   = 10'd250;
	localparam logic [SAMPLE_W-1:0] LADDER_LONG2   = 10'd120;
	localparam logic [SAMPLE_W-1:0] LADDER_LONG3   = 10'd60;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_EN   = 2'd1,
		MODE_PRT  = 2'd2,
		MODE_DIS  = 2'd3
	} mode_t;

	typedef struct packed {
		logic                cmd_pump0;
		logic                cmd_pump1;
		logic                sample_valid;
		logic                sample_pump;
		logic [SAMPLE_W-1:0] sample_value;
	} tick_t;

	typedef struct packed {
		logic drive_pump0;
		logic drive_pump1;
		logic status_pump0;
		logic status_pump1;
	} result_t;

	typedef struct packed {
		logic [DELAY_W-1:0]  delay_default;
		logic [DELAY_W-1:0]  delay_long1;
		logic [DELAY_W-1:0]  delay_long2;
		logic [DELAY_W-1:0]  delay_long3;
		logic [PERIOD_W-1:0] protect_period;
		logic [RUN_W-1:0]    protect_run;
	} cfg_t;

	typedef struct packed {
		logic drive;
		logic status;
	} lane_res_t;

endpackage

// ===== sv/dual_pump_off_delay_controller_core.sv =====
// Top level of the dual pump off-delay controller.
// Each accepted tick word updates both pumps at once: one lane per pump
// decodes the switch sample addressed to it and steps its mode sequencer, and the
// merge stage packs both lanes into the result word. A new tick can be taken every
// cycle while tick_stall is low. A two-entry output buffer lets the next tick be
// taken while a result waits; tick_stall rises only when both entries are occupied.
// Configuration sits behind an APB port (registers at byte addresses 0, 4, ... 20,
// pready always high); the user is to write it only while the block is idle, which
// the block itself does not enforce. Counters already loaded keep their values.
module dual_pump_off_delay_controller_core
	import dpodc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// tick channel
	input  logic              tick_valid,
	output logic              tick_stall,
	input  tick_t             tick,
	// result channel
	output logic              res_valid,
	input  logic              res_stall,
	output result_t           res,
	// configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_t                 cfg_q;
	logic                 cfg_wr;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 accept;
	logic                 full;
	logic [NUM_PUMPS-1:0] cmd_vec;
	lane_res_t            lane_res [NUM_PUMPS];

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	// register file; writes to unused indexes drop silently
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delay_default  <= RST_DELAY_DEFAULT;
			cfg_q.delay_long1    <= RST_DELAY_LONG1;
			cfg_q.delay_long2    <= RST_DELAY_LONG2;
			cfg_q.delay_long3    <= RST_DELAY_LONG3;
			cfg_q.protect_period <= RST_PROTECT_PERIOD;
			cfg_q.protect_run    <= RST_PROTECT_RUN;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_DELAY_DEFAULT:  cfg_q.delay_default  <= pwdata[DELAY_W-1:0];
				REG_DELAY_LONG1:    cfg_q.delay_long1    <= pwdata[DELAY_W-1:0];
				REG_DELAY_LONG2:    cfg_q.delay_long2    <= pwdata[DELAY_W-1:0];
				REG_DELAY_LONG3:    cfg_q.delay_long3    <= pwdata[DELAY_W-1:0];
				REG_PROTECT_PERIOD: cfg_q.protect_period <= pwdata[PERIOD_W-1:0];
				REG_PROTECT_RUN:    cfg_q.protect_run    <= pwdata[RUN_W-1:0];
				default: ;
			endcase
		end
	end

	// read back, zero-extended
	always_comb begin
		prdata = 32'd0;
		unique case (reg_idx)
			REG_DELAY_DEFAULT:  prdata = {16'd0, cfg_q.delay_default};
			REG_DELAY_LONG1:    prdata = {16'd0, cfg_q.delay_long1};
			REG_DELAY_LONG2:    prdata = {16'd0, cfg_q.delay_long2};
			REG_DELAY_LONG3:    prdata = {16'd0, cfg_q.delay_long3};
			REG_PROTECT_PERIOD: prdata = {15'd0, cfg_q.protect_period};
			REG_PROTECT_RUN:    prdata = {24'd0, cfg_q.protect_run};
			default:            prdata = 32'd0;
		endcase
	end

	// take a tick whenever the output buffer has room
	assign tick_stall = full;
	assign accept     = tick_valid && !tick_stall;
	assign cmd_vec    = {tick.cmd_pump1, tick.cmd_pump0};

	// one lane per pump; the sample reaches only the pump it names
	for (genvar p = 0; p < NUM_PUMPS; p++) begin : g_lane
		dpodc_lane u_lane (
			.clk          (clk),
			.arst_n       (arst_n),
			.en           (accept),
			.cmd          (cmd_vec[p]),
			.sample_hit   (tick.sample_valid && (tick.sample_pump == 1'(p))),
			.sample_value (tick.sample_value),
			.cfg          (cfg_q),
			.res          (lane_res[p])
		);
	end

	// pack both lanes and hold the result word until taken
	dpodc_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.lane_res  (lane_res),
		.full      (full),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

// ===== sv/dpodc_lane.sv =====
// One pump lane: switch sample decode, mode sequencer and counters.
module dpodc_lane
	import dpodc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                cmd,
	input  logic                sample_hit,
	input  logic [SAMPLE_W-1:0] sample_value,
	input  cfg_t                cfg,
	output lane_res_t           res
);

	mode_t               mode_q, mode_d;
	logic                drive_q, drive_d;
	logic                status_q, status_d;
	logic                prot_q, prot_d;
	logic [DELAY_W-1:0]  delay_q, delay_dec, delay_d;
	logic [PERIOD_W-1:0] idle_q, idle_d;
	logic [RUN_W-1:0]    run_q, run_d;

	// sample decode; delay loads are held off during off-delay
	always_comb begin
		logic [SAMPLE_W-1:0] v;
		logic                load;
		v         = sample_value;
		load      = (mode_q != MODE_DIS);
		prot_d    = prot_q;
		delay_dec = delay_q;
		if (sample_hit) begin
			if (v > LADDER_PROTECT) begin
				prot_d = 1'b1;
				if (load) delay_dec = cfg.delay_default;
				v = v - LADDER_PROTECT;
			end else if (v < LADDER_PROTECT) begin
				prot_d = 1'b0;
				if (load) delay_dec = cfg.delay_default;
			end
			if (v > LADDER_LONG1) begin
				if (load) delay_dec = cfg.delay_long1;
			end else if (v > LADDER_LONG2) begin
				if (load) delay_dec = cfg.delay_long2;
			end else if (v > LADDER_LONG3) begin
				if (load) delay_dec = cfg.delay_long3;
			end
		end
	end

	// next mode
	always_comb begin
		mode_d = mode_q;
		unique case (mode_q)
			MODE_IDLE: begin
				if (drive_q != cmd) mode_d = cmd ? MODE_EN : MODE_DIS;
				else if (idle_q == '0) mode_d = MODE_PRT;
			end
			MODE_EN: mode_d = MODE_IDLE;
			MODE_PRT: begin
				if (run_q == '0) mode_d = MODE_IDLE;
				else if (cmd) mode_d = MODE_EN;
			end
			MODE_DIS: begin
				if (delay_q == '0) mode_d = MODE_IDLE;
				else if (cmd) mode_d = MODE_EN;
			end
			default: mode_d = MODE_IDLE;
		endcase
	end

	// counters, drive and status
	always_comb begin
		drive_d  = drive_q;
		status_d = status_q;
		idle_d   = idle_q;
		run_d    = run_q;
		delay_d  = delay_dec;
		unique case (mode_q)
			MODE_IDLE: begin
				if (drive_q != cmd) begin
					status_d = cmd;
				end else if (idle_q == '0) begin
					idle_d   = cfg.protect_period;
					status_d = 1'b1;
					drive_d  = 1'b1;
				end else if (prot_d) begin
					idle_d = idle_q - 1'b1;
				end else begin
					idle_d = cfg.protect_period;
				end
			end
			MODE_EN: begin
				drive_d = 1'b1;
				idle_d  = cfg.protect_period;
			end
			MODE_PRT: begin
				if (run_q == '0) begin
					run_d    = cfg.protect_run;
					drive_d  = 1'b0;
					status_d = 1'b0;
				end else if (cmd) begin
					run_d    = cfg.protect_run;
					status_d = 1'b1;
				end else begin
					run_d = run_q - 1'b1;
				end
			end
			MODE_DIS: begin
				if (delay_q == '0) begin
					drive_d = 1'b0;
					idle_d  = cfg.protect_period;
				end else if (cmd) begin
					run_d    = cfg.protect_run;
					status_d = 1'b1;
				end else begin
					delay_d = delay_q - 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			drive_q  <= 1'b0;
			status_q <= 1'b0;
			prot_q   <= 1'b0;
			delay_q  <= RST_DELAY_DEFAULT;
			idle_q   <= RST_PROTECT_PERIOD;
			run_q    <= RST_PROTECT_RUN;
		end else if (en) begin
			mode_q   <= mode_d;
			drive_q  <= drive_d;
			status_q <= status_d;
			prot_q   <= prot_d;
			delay_q  <= delay_d;
			idle_q   <= idle_d;
			run_q    <= run_d;
		end
	end

	assign res.drive  = drive_d;
	assign res.status = status_d;

endmodule

// ===== sv/dpodc_merge.sv =====
// Merge of the lane results into the result word, with a two-entry output buffer.
`include "dual_pump_off_delay_controller_core_assert.svh"
module dpodc_merge
	import dpodc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  lane_res_t lane_res [NUM_PUMPS],
	output logic      full,
	output logic      res_valid,
	input  logic      res_stall,
	output result_t   res
);

	result_t    word;
	result_t    buf_q [2];
	logic [1:0] cnt_q;
	logic       pop;

	assign word.drive_pump0  = lane_res[0].drive;
	assign word.drive_pump1  = lane_res[1].drive;
	assign word.status_pump0 = lane_res[0].status;
	assign word.status_pump1 = lane_res[1].status;

	assign res_valid = (cnt_q != 2'd0);
	assign full      = (cnt_q == 2'd2);
	assign res       = buf_q[0];
	assign pop       = res_valid && !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push && pop) begin
			if (cnt_q == 2'd1) begin
				buf_q[0] <= word;
			end else begin
				buf_q[0] <= buf_q[1];
				buf_q[1] <= word;
			end
		end else if (push) begin
			buf_q[cnt_q[0]] <= word;
		end else if (pop) begin
			buf_q[0] <= buf_q[1];
		end
	end

	`DPODC_ASSERT_ALWAYS(a_cnt_legal, cnt_q != 2'd3, "output buffer count out of range")
	`DPODC_ASSERT_NEXT(a_push_fills, push && !pop, cnt_q == $past(cnt_q) + 2'd1, "push lost")
	`DPODC_ASSERT_NEXT(a_pop_drains, pop && !push, cnt_q == $past(cnt_q) - 2'd1, "pop lost")

endmodule
